FILE: src/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg: shared types and constants of the cubic bisection root finder
// Widths, fixed-point format, sequencer states and result codes.
// ----------------------------------------------------------------------------
package cbr_pkg;

    localparam int MAX_STEPS = 64;
    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 2;

    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_FIELD_W = DATA_W + STEP_W + OUT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_CUBIC    = 3'd0,
        CFG_COEF_SQUARE   = 3'd1,
        CFG_COEF_LINEAR   = 3'd2,
        CFG_COEF_CONSTANT = 3'd3,
        CFG_TOLERANCE     = 3'd4
    } t_cfg_idx;

    // Result outcome codes.
    typedef enum logic [OUT_W-1:0] {
        OUTC_ROOT    = 2'd0,
        OUTC_NO_SIGN = 2'd1,
        OUTC_LIMIT   = 2'd2
    } t_outcome;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    // Multiply steps of one polynomial evaluation.
    typedef enum logic [2:0] {
        OP_SQUARE = 3'd0,
        OP_CUBE   = 3'd1,
        OP_C3     = 3'd2,
        OP_C2     = 3'd3,
        OP_C1     = 3'd4
    } t_op;

    // Which point is being evaluated.
    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_MID  = 2'd2
    } t_phase;

endpackage

FILE: src/cubic_bisection_root.sv
// ----------------------------------------------------------------------------
// cubic_bisection_root: bisection root finder for a configured cubic
// Searches a bracket for a root of a3*x^3 + a2*x^2 + a1*x + a0 in signed
// Q16.16, using a single shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One input beat carries a bracket; one output beat carries the root estimate,
// the number of bisections and the outcome. Every evaluation of the cubic runs
// five dependent multiplies through the one 32x32 signed multiplier, each in a
// multiply state and then a round-and-saturate state, followed by a final sum
// with the constant term. A search stops at the limit of 64 bisections. The
// input is not ready while a search runs or while its result waits to be taken.
module cubic_bisection_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cbr_pkg::DATA_W-1:0]          i_cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [31:0] left_end, [63:32] right_end
    input  logic [cbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [31:0] root, [38:32] steps_taken, [40:39] outcome, rest zero
    output logic [cbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import cbr_pkg::*;

    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] SAT_MAX64  = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN64  = -64'sd2147483648;
    localparam logic signed [34:0] SAT_MAX35  = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN35  = -35'sd2147483648;
    localparam logic [STEP_W-1:0]  STEP_LIMIT = STEP_W'(MAX_STEPS);

    // Configuration registers
    logic signed [DATA_W-1:0] r_coef_cubic, r_coef_square, r_coef_linear, r_coef_constant;
    logic        [TOL_W-1:0]  r_tolerance;

    // Sequencer and datapath registers
    t_state                   r_state, n_state;
    t_op                      r_op, n_op;
    t_phase                   r_phase, n_phase;
    logic signed [DATA_W-1:0] r_low_pt, n_low_pt, r_high_pt, n_high_pt;
    logic signed [DATA_W-1:0] r_low_v, n_low_v, r_high_v, n_high_v;
    logic signed [DATA_W-1:0] r_x, n_x, r_x2, n_x2, r_x3, n_x3;
    logic signed [63:0]       r_prod, n_prod;
    logic signed [34:0]       r_acc, n_acc;
    logic [STEP_W-1:0]        r_step, n_step;

    // Output register
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_root, n_root;
    logic [STEP_W-1:0]        r_out_steps, n_out_steps;
    t_outcome                 r_outcome, n_outcome;

    // Combinational helpers
    logic signed [DATA_W-1:0] w_mul_a, w_mul_b;
    logic signed [63:0]       w_rounded;
    logic signed [DATA_W-1:0] w_rs;
    logic signed [34:0]       w_sum;
    logic signed [DATA_W-1:0] w_fv;
    logic signed [32:0]       w_diff;
    logic [32:0]              w_adiff, w_mag_lo, w_mag_hi;
    logic signed [32:0]       w_mid_sum;
    logic                     w_zero_end, w_tol_hit, w_lo_neg, w_hi_neg;
    logic signed [DATA_W-1:0] w_pick;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                            r_outcome, r_out_steps, r_root};

    // Multiplier operand selection
    always_comb begin
        unique case (r_op)
            OP_SQUARE: begin w_mul_a = r_x;           w_mul_b = r_x;  end
            OP_CUBE:   begin w_mul_a = r_x2;          w_mul_b = r_x;  end
            OP_C3:     begin w_mul_a = r_coef_cubic;  w_mul_b = r_x3; end
            OP_C2:     begin w_mul_a = r_coef_square; w_mul_b = r_x2; end
            OP_C1:     begin w_mul_a = r_coef_linear; w_mul_b = r_x;  end
            default:   begin w_mul_a = r_x;           w_mul_b = r_x;  end
        endcase
    end

    // Round half up, then saturate the registered product to 32 bits.
    always_comb begin
        w_rounded = (r_prod + ROUND_HALF) >>> FRAC_BITS;
        if (w_rounded > SAT_MAX64) begin
            w_rs = SAT_MAX64[DATA_W-1:0];
        end else if (w_rounded < SAT_MIN64) begin
            w_rs = SAT_MIN64[DATA_W-1:0];
        end else begin
            w_rs = w_rounded[DATA_W-1:0];
        end
    end

    // Final sum with the constant term, saturated once.
    always_comb begin
        w_sum = r_acc + 35'(r_coef_constant);
        if (w_sum > SAT_MAX35) begin
            w_fv = SAT_MAX35[DATA_W-1:0];
        end else if (w_sum < SAT_MIN35) begin
            w_fv = SAT_MIN35[DATA_W-1:0];
        end else begin
            w_fv = w_sum[DATA_W-1:0];
        end
    end

    // Bracket tests
    always_comb begin
        w_diff     = 33'(r_low_v) - 33'(r_high_v);
        w_adiff    = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
        w_mag_lo   = r_low_v[DATA_W-1]  ? 33'(-33'(r_low_v))  : 33'(r_low_v);
        w_mag_hi   = r_high_v[DATA_W-1] ? 33'(-33'(r_high_v)) : 33'(r_high_v);
        w_zero_end = (r_low_v == '0) || (r_high_v == '0);
        w_tol_hit  = (w_adiff < {2'b00, r_tolerance});
        w_lo_neg   = r_low_v[DATA_W-1];
        w_hi_neg   = r_high_v[DATA_W-1];
        w_pick     = (w_mag_lo > w_mag_hi) ? r_high_pt : r_low_pt;
        w_mid_sum  = 33'(r_low_pt) + 33'(r_high_pt);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_phase     = r_phase;
        n_low_pt    = r_low_pt;
        n_high_pt   = r_high_pt;
        n_low_v     = r_low_v;
        n_high_v    = r_high_v;
        n_x         = r_x;
        n_x2        = r_x2;
        n_x3        = r_x3;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_root      = r_root;
        n_out_steps = r_out_steps;
        n_outcome   = r_outcome;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_low_pt  = s_axis_tdata[DATA_W-1:0];
                    n_high_pt = s_axis_tdata[2*DATA_W-1:DATA_W];
                    n_x       = s_axis_tdata[DATA_W-1:0];
                    n_step    = '0;
                    n_phase   = PH_LOW;
                    n_op      = OP_SQUARE;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = 64'(w_mul_a) * 64'(w_mul_b);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                case (r_op)
                    OP_SQUARE: n_x2  = w_rs;
                    OP_CUBE:   n_x3  = w_rs;
                    OP_C3:     n_acc = 35'(w_rs);
                    default:   n_acc = r_acc + 35'(w_rs);
                endcase
                if (r_op == OP_C1) begin
                    n_state = ST_SUM;
                end else begin
                    n_op    = t_op'(r_op + 3'd1);
                    n_state = ST_MUL;
                end
            end
            ST_SUM: begin
                n_op = OP_SQUARE;
                unique case (r_phase)
                    PH_LOW: begin
                        n_low_v = w_fv;
                        n_x     = r_high_pt;
                        n_phase = PH_HIGH;
                        n_state = ST_MUL;
                    end
                    PH_HIGH: begin
                        n_high_v = w_fv;
                        n_state  = ST_CHECK;
                    end
                    default: begin
                        // The bisection counts even when the midpoint is an exact root.
                        n_step = r_step + 1'b1;
                        if (w_fv == '0) begin
                            n_root      = r_x;
                            n_out_steps = r_step + 1'b1;
                            n_outcome   = OUTC_ROOT;
                            n_out_valid = 1'b1;
                            n_state     = ST_DONE;
                        end else begin
                            if (w_fv[DATA_W-1] == w_lo_neg) begin
                                n_low_pt = r_x;
                                n_low_v  = w_fv;
                            end else begin
                                n_high_pt = r_x;
                                n_high_v  = w_fv;
                            end
                            n_state = ST_CHECK;
                        end
                    end
                endcase
            end
            ST_CHECK: begin
                n_out_steps = r_step;
                if (w_zero_end || w_tol_hit) begin
                    n_root      = w_pick;
                    n_outcome   = OUTC_ROOT;
                    n_out_valid = 1'b1;
                    n_state     = ST_DONE;
                end else if (r_step >= STEP_LIMIT) begin
                    n_root      = w_pick;
                    n_outcome   = OUTC_LIMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_DONE;
                end else if (w_lo_neg == w_hi_neg) begin
                    n_root      = r_low_pt;
                    n_outcome   = OUTC_NO_SIGN;
                    n_out_valid = 1'b1;
                    n_state     = ST_DONE;
                end else begin
                    // Midpoint is the floor of half the exact 33-bit sum.
                    n_x     = w_mid_sum[32:1];
                    n_phase = PH_MID;
                    n_op    = OP_SQUARE;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_op            <= OP_SQUARE;
            r_phase         <= PH_LOW;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
            r_coef_cubic    <= '0;
            r_coef_square   <= '0;
            r_coef_linear   <= 32'sd65536;
            r_coef_constant <= '0;
            r_tolerance     <= 31'd66;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_COEF_CUBIC:    r_coef_cubic    <= i_cfg_data;
                    CFG_COEF_SQUARE:   r_coef_square   <= i_cfg_data;
                    CFG_COEF_LINEAR:   r_coef_linear   <= i_cfg_data;
                    CFG_COEF_CONSTANT: r_coef_constant <= i_cfg_data;
                    CFG_TOLERANCE:     r_tolerance     <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low_pt    <= n_low_pt;
        r_high_pt   <= n_high_pt;
        r_low_v     <= n_low_v;
        r_high_v    <= n_high_v;
        r_x         <= n_x;
        r_x2        <= n_x2;
        r_x3        <= n_x3;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_root      <= n_root;
        r_out_steps <= n_out_steps;
        r_outcome   <= n_outcome;
    end

`ifndef NO_ASSERTIONS
    // A search never takes a new bracket while a result is still held.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // The bisection count never passes the limit.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LIMIT)
        else $error("bisection count beyond limit");

    // A result that hit the limit reports exactly the limit as its count.
    a_limit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_outcome == OUTC_LIMIT)) |-> (r_out_steps == STEP_LIMIT))
        else $error("iteration limit outcome with wrong count");

    // A bracket without a sign change is found before any bisection.
    a_nosign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_outcome == OUTC_NO_SIGN)) |-> (r_out_steps == '0))
        else $error("no sign change reported after bisecting");

    // A new result appears only after the search has passed through its checks.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_CHECK || $past(r_state) == ST_SUM))
        else $error("result raised from an unexpected state");
`endif

endmodule

FILE: tb/tb_cubic_bisection_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bisection_root: self-checking bench for the bisection root finder
// Streams brackets into the block under several coefficient and tolerance
// settings. A scoreboard repeats each search in Q16.16 and checks every result
// beat field by field, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cubic_bisection_root;
    import cbr_pkg::*;

    localparam int ONE            = 1 << FRAC_BITS;
    localparam int Q_MAX          = 32'sh7fff_ffff;
    localparam int Q_MIN          = 32'sh8000_0000;
    localparam logic [TOL_W-1:0] TOL_MAX = '1;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int SETTLE_CYCLES  = 64;
    localparam int IDLE_LIMIT     = 20000;
    localparam int PRINT_CAP      = 40;

    typedef struct {
        logic [DATA_W-1:0] root;
        logic [STEP_W-1:0] steps;
        t_outcome          outcome;
    } t_root_result;

    typedef enum {RX_OPEN, RX_CHOPPY, RX_BLOCKED} t_rx_mode;

    class bracket_scoreboard;
        int               a3, a2, a1, a0;
        logic [TOL_W-1:0] tol;
        t_root_result     expected_q[$];
        int               errors, roots, no_sign, limited;

        function new();
            a3 = 0;
            a2 = 0;
            a1 = ONE;
            a0 = 0;
            tol = TOL_W'(66);
        endfunction

        function void set_reg(t_cfg_idx idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_COEF_CUBIC:    a3 = data;
                CFG_COEF_SQUARE:   a2 = data;
                CFG_COEF_LINEAR:   a1 = data;
                CFG_COEF_CONSTANT: a0 = data;
                CFG_TOLERANCE:     tol = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp32(longint v);
            if (v > longint'(Q_MAX)) return Q_MAX;
            if (v < longint'(Q_MIN)) return Q_MIN;
            return int'(v);
        endfunction

        // Exact product, round half up, then saturate.
        function int qmul(int a, int b);
            longint p;
            p = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
            return clamp32(p >>> FRAC_BITS);
        endfunction

        function int poly(int x);
            int     x2, x3;
            longint s;
            x2 = qmul(x, x);
            x3 = qmul(x2, x);
            s = longint'(qmul(a3, x3)) + longint'(qmul(a2, x2))
              + longint'(qmul(a1, x)) + longint'(a0);
            return clamp32(s);
        endfunction

        function longint magnitude(int v);
            return (v < 0) ? -longint'(v) : longint'(v);
        endfunction

        function bit straddles(int lo, int hi);
            return (poly(lo) < 0) != (poly(hi) < 0);
        endfunction

        function t_root_result search_root(int lo, int hi);
            int           flo, fhi, fm, mid, n;
            longint       spread;
            bit           stop, close_enough;
            t_root_result r;
            n = 0;
            stop = 0;
            while (!stop) begin
                flo = poly(lo);
                fhi = poly(hi);
                spread = longint'(flo) - longint'(fhi);
                if (spread < 0) spread = -spread;
                close_enough = (flo == 0) || (fhi == 0) || (spread < longint'(tol));
                if (close_enough || n >= MAX_STEPS) begin
                    r.root = (magnitude(flo) > magnitude(fhi)) ? hi : lo;
                    if (close_enough) r.outcome = OUTC_ROOT;
                    else              r.outcome = OUTC_LIMIT;
                    stop = 1;
                end else if ((flo < 0) == (fhi < 0)) begin
                    r.root = lo;
                    r.outcome = OUTC_NO_SIGN;
                    stop = 1;
                end else begin
                    mid = int'((longint'(lo) + longint'(hi)) >>> 1);
                    fm = poly(mid);
                    n++;
                    if (fm == 0) begin
                        r.root = mid;
                        r.outcome = OUTC_ROOT;
                        stop = 1;
                    end else if ((fm < 0) == (flo < 0)) begin
                        lo = mid;
                    end else begin
                        hi = mid;
                    end
                end
            end
            r.steps = n[STEP_W-1:0];
            return r;
        endfunction

        function void note_bracket(int lo, int hi);
            t_root_result r;
            r = search_root(lo, hi);
            case (r.outcome)
                OUTC_ROOT:    roots++;
                OUTC_NO_SIGN: no_sign++;
                default:      limited++;
            endcase
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] beat);
            t_root_result e;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %h with nothing expected", beat));
                return;
            end
            e = expected_q.pop_front();
            if (beat[DATA_W-1:0] !== e.root)
                report($sformatf("root %h, expected %h", beat[DATA_W-1:0], e.root));
            if (beat[DATA_W +: STEP_W] !== e.steps)
                report($sformatf("steps %0d, expected %0d", beat[DATA_W +: STEP_W], e.steps));
            if (beat[DATA_W+STEP_W +: OUT_W] !== e.outcome)
                report($sformatf("outcome %0d, expected %s",
                                 beat[DATA_W+STEP_W +: OUT_W], e.outcome.name()));
            if (beat[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
                report($sformatf("padding bits not zero in %h", beat));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bracket_scoreboard sb = new();
    int       burst_left = 0;
    int       items_sent = 0;
    int       settings_used = 1;
    int       idle_cycles = 0;
    int       rx_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    always #5 i_clk = ~i_clk;

    cubic_bisection_root DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Receiver: open stretches, choppy stretches and blocked stretches in random order.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(1, (rx_mode == RX_BLOCKED) ? 300 : 400);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_CHOPPY:  m_axis_tready <= 1'($urandom_range(0, 1));
            default:    m_axis_tready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, sb.pending());
            $display("tb_cubic_bisection_root NOT OK");
            $finish;
        end
    end

    task automatic wait_all_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic apply_settings(input int c3, c2, c1, c0, input logic [TOL_W-1:0] tol);
        logic [DATA_W-1:0] vals [t_cfg_idx];
        t_cfg_idx          r;
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        vals[CFG_COEF_CUBIC]    = c3;
        vals[CFG_COEF_SQUARE]   = c2;
        vals[CFG_COEF_LINEAR]   = c1;
        vals[CFG_COEF_CONSTANT] = c0;
        // The top bit of the tolerance write is not stored, so it is left random.
        vals[CFG_TOLERANCE]     = {1'($urandom_range(0, 1)), tol};
        r = r.first();
        repeat (r.num()) begin
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= r;
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            sb.set_reg(r, vals[r]);
            r = r.next();
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_bracket(input int lo, hi);
        int gap, pick;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            gap = (pick < 5) ? 0 : (pick < 8) ? $urandom_range(1, 20) : $urandom_range(21, 600);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_bracket(lo, hi);
        items_sent++;
    endtask

    function automatic int rand_point();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
        if (pick < 6) return int'($urandom_range(0, 2 * ONE)) - ONE;
        if (pick < 8) return $signed($urandom) >>> $urandom_range(0, 20);
        if (pick < 9) return $urandom;
        case ($urandom_range(0, 3))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int rand_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return (int'($urandom_range(0, 24)) - 12) <<< (FRAC_BITS - 2);
        if (pick < 7) return int'($urandom_range(0, 2 * ONE)) - ONE;
        if (pick < 9) return $urandom;
        return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    endfunction

    function automatic logic [TOL_W-1:0] rand_tolerance();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) return '0;
        if (pick < 6) return TOL_W'($urandom_range(1, 200));
        if (pick < 8) return TOL_W'($urandom_range(201, 1 << 20));
        if (pick < 9) return TOL_W'($urandom);
        return TOL_MAX;
    endfunction

    // Mostly brackets with a sign change, so that searches run deep; the rest
    // are degenerate, narrow or raw random brackets.
    task automatic send_random_bracket();
        int lo, hi, tries, pick;
        pick = $urandom_range(0, 99);
        lo = rand_point();
        hi = rand_point();
        if (pick < 70) begin
            tries = 0;
            while (!sb.straddles(lo, hi) && tries < 12) begin
                lo = rand_point();
                hi = rand_point();
                tries++;
            end
        end else if (pick < 80) begin
            hi = lo;
        end else if (pick < 85) begin
            hi = lo + int'($urandom_range(0, 255));
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
        send_bracket(lo, hi);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset give f(x) = x with a small tolerance.
        send_bracket(-ONE, ONE);
        send_bracket(ONE, -ONE);
        send_bracket(0, 12345);
        send_bracket(5 * ONE, 5 * ONE);
        send_bracket(ONE, 2 * ONE);
        send_bracket(Q_MIN, Q_MAX);
        send_bracket(Q_MAX, Q_MIN);
        send_bracket(-3 * ONE + 7, 1000003);

        // x^3 - 2x - 5 with no tolerance: only exact zeros end early.
        apply_settings(ONE, 0, -2 * ONE, -5 * ONE, '0);
        send_bracket(2 * ONE, 3 * ONE);
        send_bracket(3 * ONE, 2 * ONE);
        send_bracket(0, 0);
        send_bracket(Q_MIN, Q_MAX);

        // Extreme coefficients, under which values can saturate.
        apply_settings(Q_MAX, Q_MIN, Q_MAX, Q_MIN, TOL_MAX);
        send_bracket(Q_MIN, Q_MAX);
        send_bracket(0, ONE);
        send_bracket(-1, 1);

        apply_settings(Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0);
        send_bracket(Q_MIN, Q_MAX);
        send_bracket(-ONE, ONE);
        send_bracket(-1, 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_settings(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                           rand_tolerance());
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) == 0) wait_all_results();
                send_random_bracket();
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Searched %0d brackets under %0d register settings, %0d mismatches.",
                 items_sent, settings_used, sb.errors);
        $display("Outcomes: %0d roots, %0d without a sign change, %0d at the step limit.",
                 sb.roots, sb.no_sign, sb.limited);
        if (sb.errors == 0) begin
            $display("tb_cubic_bisection_root OK");
        end else begin
            $display("tb_cubic_bisection_root NOT OK");
        end
        $finish;
    end
endmodule

FILE: filelist.f
src/cbr_pkg.sv
src/cubic_bisection_root.sv
tb/tb_cubic_bisection_root.sv
